FILE: design/olt_pkg.sv
// Types and constants shared by the ordered list table unit.
// No dependencies; imported by the controller, datapath and top level.
`timescale 1ns / 1ps

package olt_pkg;

  localparam int unsigned KIND_W = 3;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned CNT_W  = 7;
  localparam int unsigned OUT_W  = 16;  // found, position, length, zero pad

  // request kinds
  localparam logic [KIND_W-1:0] KIND_APPEND  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_DELETE  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_REVERSE = 3'd2;
  localparam logic [KIND_W-1:0] KIND_SEARCH  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_COUNT   = 3'd4;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    RD_PTR,
    RD_LO,
    RD_HI,
    RD_LO_NEXT
  } rd_sel_e;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_APPEND,
    WR_SHIFT,
    WR_LO,
    WR_HI
  } wr_sel_e;

  typedef struct packed {
    logic    start;      // capture request, reset pointers
    logic    issue;      // advance the scan read pipeline
    rd_sel_e rd_sel;
    wr_sel_e wr_sel;
    logic    tmp_load;
    logic    len_inc;
    logic    len_dec;
    logic    rev_step;
    logic    res_load;
    status_e res_status;
    logic    res_found;
    logic    out_load;
  } olt_cmd_t;

  typedef struct packed {
    logic hit;       // returned entry equals the operand
    logic drained;   // scan has passed the tail with nothing in flight
    logic full;
    logic empty;
    logic multi;     // more than one entry
    logic rev_more;  // another swap pair remains
  } olt_sts_t;

endpackage

FILE: design/olt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module olt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/olt_ctrl.sv
// Sequencing state machine of the ordered list table unit.
// Depends on olt_pkg; drives olt_datapath through olt_cmd_t / olt_sts_t.
`timescale 1ns / 1ps

module olt_ctrl
  import olt_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [KIND_W-1:0] in_kind_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  olt_sts_t          sts_i,
  output olt_cmd_t          cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_APPEND,
    S_DEL_SCAN,
    S_DEL_SHIFT,
    S_SRCH_SCAN,
    S_REV_RD_LO,
    S_REV_RD_HI,
    S_REV_WR_LO,
    S_REV_WR_HI,
    S_NOP,
    S_RESP
  } state_e;

  state_e   state_q, state_d;
  logic     out_valid_q, out_valid_d;
  olt_cmd_t cmd;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd         = '0;
    cmd.rd_sel  = RD_PTR;
    cmd.wr_sel  = WR_NONE;
    cmd.res_status = ST_OK;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd.start = 1'b1;
          case (in_kind_i)
            KIND_APPEND:  state_d = S_APPEND;
            KIND_DELETE:  state_d = S_DEL_SCAN;
            KIND_REVERSE: state_d = sts_i.multi ? S_REV_RD_LO : S_NOP;
            KIND_SEARCH:  state_d = S_SRCH_SCAN;
            default:      state_d = S_NOP;  // count and unused kinds
          endcase
        end
      end
      S_APPEND: begin
        cmd.res_load = 1'b1;
        if (sts_i.full) begin
          cmd.res_status = ST_FULL;
        end else begin
          cmd.wr_sel  = WR_APPEND;
          cmd.len_inc = 1'b1;
        end
        state_d = S_RESP;
      end
      S_DEL_SCAN: begin
        cmd.issue = 1'b1;
        if (sts_i.hit) begin
          state_d = S_DEL_SHIFT;
        end else if (sts_i.drained) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = sts_i.empty ? ST_EMPTY : ST_NOT_FOUND;
          state_d        = S_RESP;
        end
      end
      S_DEL_SHIFT: begin
        cmd.issue  = 1'b1;
        cmd.wr_sel = WR_SHIFT;
        if (sts_i.drained) begin
          cmd.len_dec  = 1'b1;
          cmd.res_load = 1'b1;
          state_d      = S_RESP;
        end
      end
      S_SRCH_SCAN: begin
        cmd.issue = 1'b1;
        if (sts_i.hit) begin
          cmd.res_load  = 1'b1;
          cmd.res_found = 1'b1;
          state_d       = S_RESP;
        end else if (sts_i.drained) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = ST_NOT_FOUND;
          state_d        = S_RESP;
        end
      end
      S_REV_RD_LO: begin
        cmd.rd_sel = RD_LO;
        state_d    = S_REV_RD_HI;
      end
      S_REV_RD_HI: begin
        cmd.rd_sel   = RD_HI;
        cmd.tmp_load = 1'b1;
        state_d      = S_REV_WR_LO;
      end
      S_REV_WR_LO: begin
        cmd.wr_sel = WR_LO;
        state_d    = S_REV_WR_HI;
      end
      S_REV_WR_HI: begin
        cmd.wr_sel   = WR_HI;
        cmd.rd_sel   = RD_LO_NEXT;
        cmd.rev_step = 1'b1;
        if (sts_i.rev_more) begin
          state_d = S_REV_RD_HI;
        end else begin
          cmd.res_load = 1'b1;
          state_d      = S_RESP;
        end
      end
      S_NOP: begin
        cmd.res_load = 1'b1;
        state_d      = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          cmd.out_load = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

endmodule

FILE: design/olt_datapath.sv
// Datapath of the ordered list table unit: entry RAM, length, scan and
// swap pointers, result staging and output registers. Depends on olt_pkg, olt_ram.
`timescale 1ns / 1ps

module olt_datapath
  import olt_pkg::*;
#(
  parameter int unsigned CAPACITY = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [VAL_W-1:0] in_value_i,
  input  olt_cmd_t         cmd_i,
  output olt_sts_t         sts_o,
  output status_e          out_status_o,
  output logic             out_found_o,
  output logic [CNT_W-1:0] out_position_o,
  output logic [CNT_W-1:0] out_length_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned LW = $clog2(CAPACITY + 1);

  logic [VAL_W-1:0] value_q;
  logic [LW-1:0]    len_q, len_d;
  logic [LW-1:0]    ptr_q;
  logic             rd_vld_q;
  logic [AW-1:0]    rd_idx_q;
  logic [AW-1:0]    lo_q, hi_q;
  logic [VAL_W-1:0] tmp_q;

  status_e          res_status_q;
  logic             res_found_q;
  logic [CNT_W-1:0] res_pos_q, res_len_q;
  status_e          out_status_q;
  logic             out_found_q;
  logic [CNT_W-1:0] out_pos_q, out_len_q;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [VAL_W-1:0] ram_wdata, ram_rdata;
  logic             ptr_live;

  olt_ram #(
    .WIDTH(VAL_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign ptr_live = (ptr_q < len_q);

  always_comb begin
    case (cmd_i.rd_sel)
      RD_PTR:     ram_raddr = ptr_q[AW-1:0];
      RD_LO:      ram_raddr = lo_q;
      RD_HI:      ram_raddr = hi_q;
      RD_LO_NEXT: ram_raddr = lo_q + AW'(1);
      default:    ram_raddr = ptr_q[AW-1:0];
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = lo_q;
    ram_wdata = ram_rdata;
    case (cmd_i.wr_sel)
      WR_APPEND: begin
        ram_we    = 1'b1;
        ram_waddr = len_q[AW-1:0];
        ram_wdata = value_q;
      end
      WR_SHIFT: begin
        // entry returning from index i moves down to i-1
        ram_we    = rd_vld_q;
        ram_waddr = rd_idx_q - AW'(1);
      end
      WR_LO: begin
        ram_we = 1'b1;
      end
      WR_HI: begin
        ram_we    = 1'b1;
        ram_waddr = hi_q;
        ram_wdata = tmp_q;
      end
      default: ram_we = 1'b0;
    endcase
  end

  always_comb begin
    len_d = len_q;
    if (cmd_i.len_inc) begin
      len_d = len_q + LW'(1);
    end else if (cmd_i.len_dec) begin
      len_d = len_q - LW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      len_q <= len_d;
      if (cmd_i.start) begin
        rd_vld_q <= 1'b0;
      end else if (cmd_i.issue) begin
        rd_vld_q <= ptr_live;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      value_q <= in_value_i;
      ptr_q   <= '0;
      lo_q    <= '0;
      hi_q    <= AW'(len_q - LW'(1));
    end else begin
      if (cmd_i.issue) begin
        rd_idx_q <= ptr_q[AW-1:0];
        if (ptr_live) begin
          ptr_q <= ptr_q + LW'(1);
        end
      end
      if (cmd_i.rev_step) begin
        lo_q <= lo_q + AW'(1);
        hi_q <= hi_q - AW'(1);
      end
    end
    if (cmd_i.tmp_load) begin
      tmp_q <= ram_rdata;
    end
    if (cmd_i.res_load) begin
      res_status_q <= cmd_i.res_status;
      res_found_q  <= cmd_i.res_found;
      res_pos_q    <= cmd_i.res_found ? CNT_W'(LW'(rd_idx_q) + LW'(1)) : '0;
      res_len_q    <= CNT_W'(len_d);
    end
    if (cmd_i.out_load) begin
      out_status_q <= res_status_q;
      out_found_q  <= res_found_q;
      out_pos_q    <= res_pos_q;
      out_len_q    <= res_len_q;
    end
  end

  always_comb begin
    sts_o.hit      = rd_vld_q && (ram_rdata == value_q);
    sts_o.drained  = !rd_vld_q && !ptr_live;
    sts_o.full     = (len_q == LW'(CAPACITY));
    sts_o.empty    = (len_q == '0);
    sts_o.multi    = (len_q > LW'(1));
    sts_o.rev_more = ((AW+1)'(lo_q) + (AW+1)'(2)) < (AW+1)'(hi_q);
  end

  assign out_status_o   = out_status_q;
  assign out_found_o    = out_found_q;
  assign out_position_o = out_pos_q;
  assign out_length_o   = out_len_q;

endmodule

FILE: design/ordered_list_table_unit.sv
// Top level of the ordered list table unit: stream ports, controller and datapath.
// Depends on olt_pkg, olt_ctrl, olt_datapath (and olt_ram below it).
`timescale 1ns / 1ps

// Channel   Dir  Handshake                     Payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tuser: kind; tdata: value
// m_axis    out  m_axis_tvalid/m_axis_tready   tuser: status; tdata: found,
//                                              position, length
//
// One request at a time. Search and delete walk the entry RAM one word a cycle
// through its registered read port; a search hit ends the walk. Reverse swaps
// one pair at a time over the single read and write port.
// The result sits in an output register, so the next request is taken while
// it waits; a stalled m_axis holds only the result after that one.
// Reset clears length and control; the RAM is not cleared (only entries below
// the length are ever used).

module ordered_list_table_unit
  import olt_pkg::*;
#(
  parameter int unsigned CAPACITY = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [VAL_W-1:0]  s_axis_tdata,   // [31:0] value (signed)
  input  logic [KIND_W-1:0] s_axis_tuser,   // [2:0] kind
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [OUT_W-1:0]  m_axis_tdata,   // [0] found, [7:1] position,
                                            // [14:8] length, [15] zero
  output logic [STAT_W-1:0] m_axis_tuser    // [1:0] status
);

  olt_cmd_t         cmd;
  olt_sts_t         sts;
  status_e          out_status;
  logic             out_found;
  logic [CNT_W-1:0] out_position;
  logic [CNT_W-1:0] out_length;

  olt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_kind_i  (s_axis_tuser),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  olt_datapath #(
    .CAPACITY(CAPACITY)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_value_i    (s_axis_tdata),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_status_o  (out_status),
    .out_found_o   (out_found),
    .out_position_o(out_position),
    .out_length_o  (out_length)
  );

  assign m_axis_tuser = out_status;
  assign m_axis_tdata = {1'b0, out_length, out_position, out_found};

  // one request in flight: an accept is never followed directly by another
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request accepted while another is in progress");

  // a found result always carries a non-zero position and the reverse
  a_found_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[0] == (m_axis_tdata[7:1] != '0)))
    else $error("found flag and position disagree");

  // a hit is always reported with status ok
  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tuser == ST_OK)
    else $error("found result with non-ok status");

  // full status only when the list holds exactly CAPACITY entries
  a_full_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ST_FULL) |-> m_axis_tdata[14:8] == CNT_W'(CAPACITY))
    else $error("full status with wrong length");

endmodule

FILE: tb/sv/ordered_list_table_unit_tb.sv
// Self-checking testbench for ordered_list_table_unit: stream requests in, one result per item out.
// Depends on olt_pkg and the RTL; predicts each result from its own copy of the list.
`timescale 1ns / 1ps

module ordered_list_table_unit_tb;
  import olt_pkg::*;

  localparam int unsigned CAPACITY    = 64;
  localparam int unsigned IDLE_LIMIT  = 4000;              // cycles with no item moving
  localparam int unsigned DRAIN_CYCLES = 3 * CAPACITY / 2 + 8;  // a full reverse and some

  // Kinds above count are spare codes: the block must treat them as no-ops
  localparam logic [KIND_W-1:0] KIND_UNUSED_FIRST = KIND_COUNT + KIND_W'(1);
  localparam logic [KIND_W-1:0] KIND_UNUSED_LAST  = '1;

  typedef struct packed {
    status_e          status;
    logic             found;
    logic [CNT_W-1:0] position;
    logic [CNT_W-1:0] length;
  } list_result_t;

  typedef enum logic [1:0] {
    READY_ALWAYS,   // no back-pressure at all
    READY_COIN,     // stall on every other cycle or so
    READY_WINDOW,   // short open windows between longer stalls
    READY_SPARSE    // rare single-cycle stalls
  } ready_mode_e;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [VAL_W-1:0]  s_axis_tdata  = '0;
  logic [KIND_W-1:0] s_axis_tuser  = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [OUT_W-1:0]  m_axis_tdata;
  logic [STAT_W-1:0] m_axis_tuser;

  // Predictor state: the list as the block should hold it, head first
  logic [VAL_W-1:0] held_values[$];
  list_result_t     awaited_results[$];
  int unsigned      mismatch_count = 0;

  // Sender pacing
  int unsigned burst_left   = 0;
  bit          sender_eager = 1'b0;

  // Receiver pacing
  ready_mode_e ready_mode       = READY_ALWAYS;
  int unsigned ready_phase_left = 0;

  int unsigned idle_cycles = 0;

  // Values that recur often, so that duplicates and the sign boundary get exercised
  logic [VAL_W-1:0] operand_pool [8] = '{
    32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
    32'h0000_0001, 32'h0000_0002, 32'h0000_0100, 32'hDEAD_BEEF
  };

  ordered_list_table_unit #(
    .CAPACITY(CAPACITY)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Applies one request to the held list and returns the result the block owes for it.
  function automatic list_result_t apply_request(input logic [KIND_W-1:0] kind,
                                                 input logic [VAL_W-1:0]  value);
    list_result_t     res;
    int               hit;
    logic [VAL_W-1:0] flipped[$];
    res.status   = ST_OK;
    res.found    = 1'b0;
    res.position = '0;
    hit = -1;
    foreach (held_values[i]) begin
      if (hit < 0 && held_values[i] == value) hit = i;
    end
    case (kind)
      KIND_APPEND: begin
        if (held_values.size() >= CAPACITY) res.status = ST_FULL;
        else held_values.push_back(value);
      end
      KIND_DELETE: begin
        if (held_values.size() == 0) res.status = ST_EMPTY;
        else if (hit < 0) res.status = ST_NOT_FOUND;
        else held_values.delete(hit);
      end
      KIND_REVERSE: begin
        foreach (held_values[i]) flipped.push_front(held_values[i]);
        held_values = flipped;
      end
      KIND_SEARCH: begin
        if (hit < 0) begin
          res.status = ST_NOT_FOUND;
        end else begin
          res.found    = 1'b1;
          res.position = CNT_W'(hit + 1);
        end
      end
      default: ;  // count and the spare kinds leave the list alone
    endcase
    res.length = CNT_W'(held_values.size());
    return res;
  endfunction

  // Operand mix: mostly values already held, then pool values, then anything.
  function automatic logic [VAL_W-1:0] pick_operand();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55 && held_values.size() != 0)
      return held_values[$urandom_range(0, held_values.size() - 1)];
    if (roll < 80) return operand_pool[$urandom_range(0, 7)];
    return $urandom();
  endfunction

  // Offers one item and returns once it is taken; the expectation is queued at the
  // accepting edge. Between bursts tvalid may drop for a random gap with junk on the bus.
  task automatic send_request(input logic [KIND_W-1:0] kind, input logic [VAL_W-1:0] value);
    int unsigned gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    s_axis_tuser  <= kind;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    awaited_results.push_back(apply_request(kind, value));
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (sender_eager || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= $urandom();
        s_axis_tuser  <= KIND_W'($urandom());
        repeat (gap) @(posedge clk_i);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic check_field(input string name, input int unsigned expected,
                             input int unsigned actual);
    if (expected != actual) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expected, actual);
    end
  endtask

  // Every operation but append on an empty list, the spare kinds included.
  task automatic test_empty_list();
    send_request(KIND_COUNT, 32'h0);
    send_request(KIND_REVERSE, 32'h0);
    send_request(KIND_DELETE, 32'h0);
    send_request(KIND_SEARCH, 32'h7FFF_FFFF);
    for (int k = KIND_UNUSED_FIRST; k <= KIND_UNUSED_LAST; k++)
      send_request(k[KIND_W-1:0], 32'hFFFF_FFFF);
  endtask

  // Extreme operands, a duplicate, first-match delete, misses and a reverse.
  task automatic test_edge_values();
    send_request(KIND_APPEND, 32'h8000_0000);
    send_request(KIND_APPEND, 32'h7FFF_FFFF);
    send_request(KIND_APPEND, 32'h0000_0000);
    send_request(KIND_APPEND, 32'hFFFF_FFFF);
    send_request(KIND_APPEND, 32'h7FFF_FFFF);
    send_request(KIND_SEARCH, 32'h7FFF_FFFF);
    send_request(KIND_SEARCH, 32'hFFFF_FFFF);
    send_request(KIND_SEARCH, 32'h0000_0001);
    send_request(KIND_DELETE, 32'h7FFF_FFFF);
    send_request(KIND_DELETE, 32'h1234_5678);
    send_request(KIND_REVERSE, 32'h0);
    send_request(KIND_SEARCH, 32'h7FFF_FFFF);
    send_request(KIND_COUNT, 32'h5555_5555);
    send_request(KIND_UNUSED_FIRST, 32'hAAAA_AAAA);
  endtask

  // Fill to capacity, push against the full list, then drain it item by item.
  task automatic test_full_list();
    while (held_values.size() < CAPACITY) send_request(KIND_APPEND, pick_operand());
    repeat (3) send_request(KIND_APPEND, $urandom());
    send_request(KIND_SEARCH, held_values[CAPACITY - 1]);
    send_request(KIND_REVERSE, 32'h0);
    send_request(KIND_SEARCH, held_values[CAPACITY - 1]);
    send_request(KIND_COUNT, 32'h0);
    send_request(KIND_DELETE, held_values[0]);
    send_request(KIND_APPEND, $urandom());
    send_request(KIND_APPEND, $urandom());
    while (held_values.size() != 0)
      send_request(KIND_DELETE, held_values[$urandom_range(0, held_values.size() - 1)]);
    send_request(KIND_DELETE, $urandom());
  endtask

  // Random traffic steered towards a wandering target length, so the list spends
  // time everywhere from empty to full; spare kinds do not count towards n.
  task automatic test_random_mix(input int unsigned n);
    int unsigned done_items;
    int unsigned target_len;
    int unsigned retarget_left;
    int unsigned roll;
    done_items    = 0;
    retarget_left = 0;
    target_len    = 0;
    while (done_items < n) begin
      if (retarget_left == 0) begin
        target_len    = $urandom_range(0, CAPACITY);
        retarget_left = $urandom_range(30, 150);
        sender_eager  = ($urandom_range(0, 4) == 0);
      end
      retarget_left--;
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        send_request(KIND_W'($urandom_range(KIND_UNUSED_FIRST, KIND_UNUSED_LAST)),
                     $urandom());
        continue;
      end
      if (roll < 13) send_request(KIND_REVERSE, $urandom());
      else if (roll < 18) send_request(KIND_COUNT, $urandom());
      else if (roll < 48) send_request(KIND_SEARCH, pick_operand());
      else if (held_values.size() <= target_len) send_request(KIND_APPEND, pick_operand());
      else send_request(KIND_DELETE, pick_operand());
      done_items++;
    end
    sender_eager = 1'b0;
  endtask

  // Receiver back-pressure: a new mode is picked at random at the end of each phase.
  always @(posedge clk_i) begin
    if (ready_phase_left == 0) begin
      ready_mode       <= ready_mode_e'($urandom_range(0, 3));
      ready_phase_left <= $urandom_range(20, 300);
      m_axis_tready    <= 1'b1;
    end else begin
      ready_phase_left <= ready_phase_left - 1;
      case (ready_mode)
        READY_ALWAYS: m_axis_tready <= 1'b1;
        READY_COIN:   m_axis_tready <= ($urandom_range(0, 1) == 0);
        READY_WINDOW: m_axis_tready <= ((ready_phase_left % 7) < 2);
        default:      m_axis_tready <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  // Result check: each accepted item against the oldest expectation.
  always @(posedge clk_i) begin : result_check
    list_result_t exp_res;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (awaited_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: result with nothing expected, expected none, actual status %0d data %h",
                 $time, m_axis_tuser, m_axis_tdata);
      end else begin
        exp_res = awaited_results.pop_front();
        check_field("status", 32'(exp_res.status), 32'(m_axis_tuser));
        check_field("found", 32'(exp_res.found), 32'(m_axis_tdata[0]));
        check_field("position", 32'(exp_res.position), 32'(m_axis_tdata[7:1]));
        check_field("length", 32'(exp_res.length), 32'(m_axis_tdata[14:8]));
        check_field("pad bit", 0, 32'(m_axis_tdata[15]));
      end
    end
  end

  // Watchdog: too long without any item moving on either side ends the run.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_empty_list();
    test_edge_values();
    test_full_list();
    test_random_mix(1750);

    s_axis_tvalid <= 1'b0;
    // Wait out the remaining results, then give the block time to show any stray one
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0 && awaited_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
